[rtl/assert_macros.svh]
// Assertion macros shared by the max-flow engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that holds at every clock edge outside reset.
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication.
`define CHK_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
// Next-cycle implication.
`define CHK_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`endif

[rtl/mflge_pkg.sv]
// Package: payload types, sequencer op codes and controller/datapath links.
package mflge_pkg;

  localparam int DEF_MAX_NODES = 256;
  localparam int DEF_MAX_EDGES = 1024;
  localparam int DEF_CAP_BITS  = 16;
  localparam int FLOW_W        = 26;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SINK   = 1'b1;

  typedef struct packed {
    logic [7:0]  edge_from;
    logic [7:0]  edge_to;
    logic [15:0] edge_capacity;
    logic        last_edge;
  } in_item_t;

  typedef struct packed {
    logic [FLOW_W-1:0] total_flow;
    logic              edges_dropped;
  } out_item_t;

  localparam int OP_W = 6;
  localparam logic [OP_W-1:0] OP_CLEAR    = 6'd0;
  localparam logic [OP_W-1:0] OP_IDLE     = 6'd1;
  localparam logic [OP_W-1:0] OP_LINK1    = 6'd2;
  localparam logic [OP_W-1:0] OP_LINK2    = 6'd3;
  localparam logic [OP_W-1:0] OP_BFS_INIT = 6'd4;
  localparam logic [OP_W-1:0] OP_BFS_POP  = 6'd5;
  localparam logic [OP_W-1:0] OP_BFS_X    = 6'd6;
  localparam logic [OP_W-1:0] OP_BFS_XL   = 6'd7;
  localparam logic [OP_W-1:0] OP_BFS_ARC  = 6'd8;
  localparam logic [OP_W-1:0] OP_BFS_AR   = 6'd9;
  localparam logic [OP_W-1:0] OP_BFS_CHK  = 6'd10;
  localparam logic [OP_W-1:0] OP_BFS_END  = 6'd11;
  localparam logic [OP_W-1:0] OP_BFS_T    = 6'd12;
  localparam logic [OP_W-1:0] OP_COPY_RD  = 6'd13;
  localparam logic [OP_W-1:0] OP_COPY_WR  = 6'd14;
  localparam logic [OP_W-1:0] OP_DFS_U    = 6'd15;
  localparam logic [OP_W-1:0] OP_DFS_UL   = 6'd16;
  localparam logic [OP_W-1:0] OP_DFS_ARC  = 6'd17;
  localparam logic [OP_W-1:0] OP_DFS_AR   = 6'd18;
  localparam logic [OP_W-1:0] OP_DFS_CHK  = 6'd19;
  localparam logic [OP_W-1:0] OP_DFS_STOP = 6'd20;
  localparam logic [OP_W-1:0] OP_DFS_POP  = 6'd21;
  localparam logic [OP_W-1:0] OP_DFS_POP2 = 6'd22;
  localparam logic [OP_W-1:0] OP_AUG_INIT = 6'd23;
  localparam logic [OP_W-1:0] OP_AUG_MA   = 6'd24;
  localparam logic [OP_W-1:0] OP_AUG_MR   = 6'd25;
  localparam logic [OP_W-1:0] OP_AUG_U0   = 6'd26;
  localparam logic [OP_W-1:0] OP_AUG_UA   = 6'd27;
  localparam logic [OP_W-1:0] OP_AUG_UF   = 6'd28;
  localparam logic [OP_W-1:0] OP_AUG_UB   = 6'd29;
  localparam logic [OP_W-1:0] OP_AUG_END  = 6'd30;
  localparam logic [OP_W-1:0] OP_AUG_T1   = 6'd31;
  localparam logic [OP_W-1:0] OP_AUG_T2   = 6'd32;
  localparam logic [OP_W-1:0] OP_DONE     = 6'd33;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            take;
  } cmd_t;

  typedef struct packed {
    logic in_ok;
    logic arc_full;
    logic in_last;
    logic item_last;
    logic ends_bad;
    logic arc_none;
    logic q_empty;
    logic t_reached;
    logic sweep_last;
    logic at_sink;
    logic dfs_ok;
    logic depth_zero;
    logic aug_last;
    logic out_busy;
  } status_t;

endpackage

[rtl/max_flow_level_graph_engine_top.sv]
// Top level of the max-flow engine: sequencer plus datapath.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_data  (edge_from, edge_to, capacity, last)
//  out_    | output    | out_valid/out_stall| out_data (total_flow, edges_dropped)
//  cfg_    | input     | cfg_wr_en          | cfg_index, cfg_wdata
//
// A stored edge passes through the LINK1 and LINK2 states; an ignored or dropped one does not:
// the adjacency insert reads and rewrites two list heads through one RAM port.
// After the last edge the flow run is data dependent: each level pass and path search
// steps through the ARC, AR and CHK states for each scanned arc, each round reloads the
// current-arc table, and each augment finds the path minimum and then updates each path arc.
// Reset and every result start a sweep over all MAX_NODES nodes that empties the adjacency
// heads; in_stall stays high through it and through the whole flow run.
// A result waits in the output register under out_stall while new edges load.
module max_flow_level_graph_engine_top
  import mflge_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_EDGES = DEF_MAX_EDGES,
  parameter int CAP_BITS  = DEF_CAP_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Command from sequencer, status back from datapath.
  cmd_t    cmd;
  status_t st;

  mflge_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Datapath owns all storage, the config registers and the output register.
  mflge_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES),
    .CAP_BITS  (CAP_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .st        (st)
  );

endmodule

[rtl/mflge_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mflge_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [$clog2(D)-1:0] wr_addr,
  input  logic [W-1:0]         wr_data,
  input  logic [$clog2(D)-1:0] rd_addr,
  output logic [W-1:0]         rd_data
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/mflge_ctrl.sv]
// Sequencer for edge loading, level labeling, blocking flow and store clearing.
`include "assert_macros.svh"
module mflge_ctrl
  import mflge_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  status_t st,
  output logic    in_stall,
  output cmd_t    cmd
);

  logic [OP_W-1:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= OP_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      OP_CLEAR:    state_nxt = st.sweep_last ? OP_IDLE : OP_CLEAR;
      OP_IDLE: begin
        if (in_valid) begin
          if (st.in_ok && !st.arc_full) begin
            state_nxt = OP_LINK1;
          end else if (st.in_last) begin
            state_nxt = OP_BFS_INIT;
          end
        end
      end
      OP_LINK1:    state_nxt = OP_LINK2;
      OP_LINK2:    state_nxt = st.item_last ? OP_BFS_INIT : OP_IDLE;
      OP_BFS_INIT: state_nxt = st.ends_bad ? OP_DONE : OP_BFS_POP;
      OP_BFS_POP:  state_nxt = st.q_empty ? OP_BFS_END : OP_BFS_X;
      OP_BFS_X:    state_nxt = OP_BFS_XL;
      OP_BFS_XL:   state_nxt = OP_BFS_ARC;
      OP_BFS_ARC:  state_nxt = st.arc_none ? OP_BFS_POP : OP_BFS_AR;
      OP_BFS_AR:   state_nxt = OP_BFS_CHK;
      OP_BFS_CHK:  state_nxt = OP_BFS_ARC;
      OP_BFS_END:  state_nxt = OP_BFS_T;
      OP_BFS_T:    state_nxt = st.t_reached ? OP_COPY_RD : OP_DONE;
      OP_COPY_RD:  state_nxt = OP_COPY_WR;
      OP_COPY_WR:  state_nxt = st.sweep_last ? OP_DFS_U : OP_COPY_RD;
      OP_DFS_U:    state_nxt = st.at_sink ? OP_AUG_INIT : OP_DFS_UL;
      OP_DFS_UL:   state_nxt = OP_DFS_ARC;
      OP_DFS_ARC:  state_nxt = st.arc_none ? OP_DFS_STOP : OP_DFS_AR;
      OP_DFS_AR:   state_nxt = OP_DFS_CHK;
      OP_DFS_CHK:  state_nxt = st.dfs_ok ? OP_DFS_U : OP_DFS_ARC;
      OP_DFS_STOP: state_nxt = st.depth_zero ? OP_BFS_INIT : OP_DFS_POP;
      OP_DFS_POP:  state_nxt = OP_DFS_POP2;
      OP_DFS_POP2: state_nxt = OP_DFS_U;
      OP_AUG_INIT: state_nxt = OP_AUG_MA;
      OP_AUG_MA:   state_nxt = OP_AUG_MR;
      OP_AUG_MR:   state_nxt = st.aug_last ? OP_AUG_U0 : OP_AUG_MA;
      OP_AUG_U0:   state_nxt = OP_AUG_UA;
      OP_AUG_UA:   state_nxt = OP_AUG_UF;
      OP_AUG_UF:   state_nxt = OP_AUG_UB;
      OP_AUG_UB:   state_nxt = st.aug_last ? OP_AUG_END : OP_AUG_U0;
      OP_AUG_END:  state_nxt = OP_AUG_T1;
      OP_AUG_T1:   state_nxt = OP_AUG_T2;
      OP_AUG_T2:   state_nxt = OP_DFS_U;
      OP_DONE:     state_nxt = st.out_busy ? OP_DONE : OP_CLEAR;
      default:     state_nxt = OP_CLEAR;
    endcase
  end

  assign in_stall = (state_r != OP_IDLE);
  assign cmd.op   = state_r;
  assign cmd.take = (state_r == OP_IDLE) && in_valid;

  `CHK_IMPLY(a_aug_needs_path, state_r == OP_AUG_INIT, !st.depth_zero, "augment with empty path")
  `CHK_NEXT(a_take_next, cmd.take, state_r == OP_IDLE || state_r == OP_LINK1 || state_r == OP_BFS_INIT, "bad state after transaction")

endmodule

[rtl/mflge_dp.sv]
// Datapath: arc store, node tables, search queue, path stack and flow registers.
`include "assert_macros.svh"
module mflge_dp
  import mflge_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_EDGES = DEF_MAX_EDGES,
  parameter int CAP_BITS  = DEF_CAP_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  in_item_t              in_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  out_stall,
  output logic                  out_valid,
  output out_item_t             out_data,
  output status_t               st
);

  localparam int NW   = $clog2(MAX_NODES);
  localparam int ARCS = 2 * MAX_EDGES;
  localparam int AW   = $clog2(ARCS);
  localparam int PW   = AW + 1;
  localparam int EW   = NW + 1;
  localparam int MW   = EW + NW;
  localparam int CW   = CAP_BITS;
  localparam int DW   = NW + 1;
  localparam logic [PW-1:0] NONE_PTR = {1'b1, {AW{1'b0}}};

  logic [7:0]        src_r, snk_r;
  logic [NW-1:0]     from_r, to_r;
  logic [CW-1:0]     cap_r;
  logic              last_r;
  logic [AW:0]       cnt_r;
  logic              ovf_r;
  logic [FLOW_W-1:0] total_r, total_nxt;
  logic [EW-1:0]     epoch_r;
  logic [NW-1:0]     sweep_r, sweep_nxt;
  logic [NW:0]       qh_r, qt_r;
  logic [NW-1:0]     u_r, h_r, lvl_r;
  logic [PW-1:0]     a_r, nx_r;
  logic              pos_r;
  logic [DW-1:0]     depth_r, i_r, cut_r, i_p1, depth_m1;
  logic [CW-1:0]     b_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [NW+7:0]       from_x, to_x, src_x, snk_x;
  logic [CW+15:0]      cap_x;
  logic [CW+FLOW_W-1:0] b_x;
  logic [NW-1:0]       from_n, to_n, src_n, snk_n;
  logic                from_ok, to_ok, src_ok, snk_ok;

  logic            first_we, cur_we, mark_we, queue_we, stack_we, head_we, res_we, next_we;
  logic [NW-1:0]   first_wa, first_ra, cur_wa, cur_ra, mark_wa, mark_ra;
  logic [NW-1:0]   queue_wa, queue_ra, stack_wa, stack_ra;
  logic [AW-1:0]   head_wa, head_ra, res_wa, res_ra, next_wa, next_ra;
  logic [PW-1:0]   first_wd, first_rd, cur_wd, cur_rd, next_wd, next_rd;
  logic [MW-1:0]   mark_wd, mark_rd;
  logic [NW-1:0]   queue_wd, queue_rd, head_wd, head_rd;
  logic [AW-1:0]   stack_wd, stack_rd, arc0, arc1;
  logic [CW-1:0]   res_wd, res_rd;
  logic [EW-1:0]   mark_ep;
  logic [NW-1:0]   mark_lvl;
  logic            bfs_take, dfs_ok;

  assign from_x  = {{NW{1'b0}}, in_data.edge_from};
  assign to_x    = {{NW{1'b0}}, in_data.edge_to};
  assign src_x   = {{NW{1'b0}}, src_r};
  assign snk_x   = {{NW{1'b0}}, snk_r};
  assign from_ok = from_x < (NW+8)'(MAX_NODES);
  assign to_ok   = to_x < (NW+8)'(MAX_NODES);
  assign src_ok  = src_x < (NW+8)'(MAX_NODES);
  assign snk_ok  = snk_x < (NW+8)'(MAX_NODES);
  assign from_n  = from_x[NW-1:0];
  assign to_n    = to_x[NW-1:0];
  assign src_n   = src_x[NW-1:0];
  assign snk_n   = snk_x[NW-1:0];
  assign cap_x   = {{CW{1'b0}}, in_data.edge_capacity};
  assign b_x     = {{FLOW_W{1'b0}}, b_r};
  assign total_nxt = total_r + b_x[FLOW_W-1:0];
  assign sweep_nxt = (sweep_r == NW'(MAX_NODES - 1)) ? '0 : sweep_r + NW'(1);

  assign arc0     = cnt_r[AW-1:0];
  assign arc1     = cnt_r[AW-1:0] | AW'(1);
  assign i_p1     = i_r + DW'(1);
  assign depth_m1 = depth_r - DW'(1);
  assign mark_ep  = mark_rd[MW-1:NW];
  assign mark_lvl = mark_rd[NW-1:0];
  assign bfs_take = pos_r && (mark_ep != epoch_r);
  assign dfs_ok   = pos_r && (mark_ep == epoch_r) &&
                    ({1'b0, mark_lvl} == ({1'b0, lvl_r} + DW'(1)));

  always_comb begin
    first_we = 1'b0; first_wa = '0; first_wd = '0; first_ra = '0;
    cur_we   = 1'b0; cur_wa   = '0; cur_wd   = '0; cur_ra   = '0;
    mark_we  = 1'b0; mark_wa  = '0; mark_wd  = '0; mark_ra  = '0;
    queue_we = 1'b0; queue_wa = '0; queue_wd = '0; queue_ra = '0;
    stack_we = 1'b0; stack_wa = '0; stack_wd = '0; stack_ra = '0;
    head_we  = 1'b0; head_wa  = '0; head_wd  = '0; head_ra  = '0;
    res_we   = 1'b0; res_wa   = '0; res_wd   = '0; res_ra   = '0;
    next_we  = 1'b0; next_wa  = '0; next_wd  = '0; next_ra  = '0;
    unique case (cmd.op)
      OP_CLEAR: begin
        first_we = 1'b1; first_wa = sweep_r; first_wd = NONE_PTR;
        mark_we  = 1'b1; mark_wa  = sweep_r; mark_wd  = '0;
      end
      OP_IDLE: first_ra = from_n;
      OP_LINK1: begin
        next_we  = 1'b1; next_wa  = arc0; next_wd = first_rd;
        first_we = 1'b1; first_wa = from_r; first_wd = {1'b0, arc0};
        head_we  = 1'b1; head_wa  = arc0; head_wd = to_r;
        res_we   = 1'b1; res_wa   = arc0; res_wd  = cap_r;
        first_ra = to_r;
      end
      OP_LINK2: begin
        // Self loop: the head of the list is arc0, written in LINK1.
        next_we  = 1'b1; next_wa  = arc1;
        next_wd  = (from_r == to_r) ? {1'b0, arc0} : first_rd;
        first_we = 1'b1; first_wa = to_r; first_wd = {1'b0, arc1};
        head_we  = 1'b1; head_wa  = arc1; head_wd = from_r;
        res_we   = 1'b1; res_wa   = arc1; res_wd  = '0;
      end
      OP_BFS_INIT: begin
        queue_we = 1'b1; queue_wa = '0; queue_wd = src_n;
        mark_we  = 1'b1; mark_wa  = src_n; mark_wd = {epoch_r + EW'(1), {NW{1'b0}}};
      end
      OP_BFS_POP: queue_ra = qh_r[NW-1:0];
      OP_BFS_X: begin
        first_ra = queue_rd; mark_ra = queue_rd;
      end
      OP_BFS_ARC, OP_DFS_ARC: begin
        head_ra = a_r[AW-1:0]; res_ra = a_r[AW-1:0]; next_ra = a_r[AW-1:0];
      end
      OP_BFS_AR, OP_DFS_AR: mark_ra = head_rd;
      OP_BFS_CHK: begin
        if (bfs_take) begin
          mark_we  = 1'b1; mark_wa  = h_r; mark_wd = {epoch_r, lvl_r + NW'(1)};
          queue_we = 1'b1; queue_wa = qt_r[NW-1:0]; queue_wd = h_r;
        end
      end
      OP_BFS_END: mark_ra = snk_n;
      OP_COPY_RD: first_ra = sweep_r;
      OP_COPY_WR: begin
        cur_we = 1'b1; cur_wa = sweep_r; cur_wd = first_rd;
      end
      OP_DFS_U: begin
        cur_ra = u_r; mark_ra = u_r;
      end
      OP_DFS_CHK: begin
        if (dfs_ok) begin
          cur_we   = 1'b1; cur_wa   = u_r; cur_wd = a_r;
          stack_we = 1'b1; stack_wa = depth_r[NW-1:0]; stack_wd = a_r[AW-1:0];
        end
      end
      OP_DFS_STOP: begin
        cur_we = 1'b1; cur_wa = u_r; cur_wd = NONE_PTR;
        stack_ra = depth_m1[NW-1:0];
      end
      OP_DFS_POP: begin
        head_ra = stack_rd ^ AW'(1); next_ra = stack_rd;
      end
      OP_DFS_POP2: begin
        cur_we = 1'b1; cur_wa = head_rd; cur_wd = next_rd;
      end
      OP_AUG_INIT: stack_ra = '0;
      OP_AUG_MA:   res_ra = stack_rd;
      OP_AUG_MR:   stack_ra = i_p1[NW-1:0];
      OP_AUG_U0:   stack_ra = i_r[NW-1:0];
      OP_AUG_UA:   res_ra = stack_rd;
      OP_AUG_UF: begin
        res_we = 1'b1; res_wa = a_r[AW-1:0]; res_wd = res_rd - b_r;
        res_ra = a_r[AW-1:0] ^ AW'(1);
      end
      OP_AUG_UB: begin
        res_we = 1'b1; res_wa = a_r[AW-1:0] ^ AW'(1); res_wd = res_rd + b_r;
      end
      OP_AUG_END: stack_ra = cut_r[NW-1:0];
      OP_AUG_T1:  head_ra = stack_rd ^ AW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r       <= '0;
      snk_r       <= 8'd1;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      total_r     <= '0;
      epoch_r     <= '0;
      sweep_r     <= '0;
      qh_r        <= '0;
      qt_r        <= '0;
      depth_r     <= '0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_SOURCE: src_r <= cfg_wdata;
          REG_SINK:   snk_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        OP_CLEAR, OP_COPY_WR: sweep_r <= sweep_nxt;
        OP_IDLE: begin
          if (cmd.take) begin
            from_r <= from_n;
            to_r   <= to_n;
            cap_r  <= cap_x[CW-1:0];
            last_r <= in_data.last_edge;
            if (from_ok && to_ok && st.arc_full) begin
              ovf_r <= 1'b1;
            end
          end
        end
        OP_LINK2: cnt_r <= cnt_r + (AW+1)'(2);
        OP_BFS_INIT: begin
          epoch_r <= epoch_r + EW'(1);
          qh_r    <= '0;
          qt_r    <= (NW+1)'(1);
        end
        OP_BFS_POP: begin
          if (qh_r != qt_r) begin
            qh_r <= qh_r + (NW+1)'(1);
          end
        end
        OP_BFS_XL: begin
          a_r <= first_rd; lvl_r <= mark_lvl;
        end
        OP_DFS_UL: begin
          a_r <= cur_rd; lvl_r <= mark_lvl;
        end
        OP_BFS_AR, OP_DFS_AR: begin
          h_r <= head_rd; pos_r <= (res_rd != '0); nx_r <= next_rd;
        end
        OP_BFS_CHK: begin
          if (bfs_take) begin
            qt_r <= qt_r + (NW+1)'(1);
          end
          a_r <= nx_r;
        end
        OP_BFS_T: begin
          u_r <= src_n; depth_r <= '0;
        end
        OP_DFS_CHK: begin
          if (dfs_ok) begin
            depth_r <= depth_r + DW'(1);
            u_r     <= h_r;
          end else begin
            a_r <= nx_r;
          end
        end
        OP_DFS_STOP: begin
          if (depth_r != '0) begin
            depth_r <= depth_m1;
          end
        end
        OP_DFS_POP2, OP_AUG_T2: u_r <= head_rd;
        OP_AUG_INIT: i_r <= '0;
        OP_AUG_MR: begin
          // Keep the first smallest residual: the path is cut back to it.
          if (i_r == '0 || res_rd < b_r) begin
            b_r <= res_rd; cut_r <= i_r;
          end
          i_r <= (i_p1 == depth_r) ? '0 : i_p1;
        end
        OP_AUG_UA: a_r <= {1'b0, stack_rd};
        OP_AUG_UB: i_r <= i_p1;
        OP_AUG_END: begin
          total_r <= total_nxt; depth_r <= cut_r;
        end
        OP_DONE: begin
          if (!out_valid_r) begin
            out_valid_r              <= 1'b1;
            out_data_r.total_flow    <= total_r;
            out_data_r.edges_dropped <= ovf_r;
            cnt_r   <= '0;
            ovf_r   <= 1'b0;
            total_r <= '0;
            epoch_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign st.in_ok      = from_ok && to_ok;
  assign st.arc_full   = (cnt_r == (AW+1)'(ARCS));
  assign st.in_last    = in_data.last_edge;
  assign st.item_last  = last_r;
  assign st.ends_bad   = !src_ok || !snk_ok || (src_r == snk_r);
  assign st.arc_none   = a_r[AW];
  assign st.q_empty    = (qh_r == qt_r);
  assign st.t_reached  = (mark_ep == epoch_r);
  assign st.sweep_last = (sweep_r == NW'(MAX_NODES - 1));
  assign st.at_sink    = (u_r == snk_n);
  assign st.dfs_ok     = dfs_ok;
  assign st.depth_zero = (depth_r == '0);
  assign st.aug_last   = (i_p1 == depth_r);
  assign st.out_busy   = out_valid_r;

  mflge_ram #(.W(PW), .D(MAX_NODES)) u_first (
    .clk(clk), .wr_en(first_we), .wr_addr(first_wa), .wr_data(first_wd),
    .rd_addr(first_ra), .rd_data(first_rd));
  mflge_ram #(.W(PW), .D(MAX_NODES)) u_cur (
    .clk(clk), .wr_en(cur_we), .wr_addr(cur_wa), .wr_data(cur_wd),
    .rd_addr(cur_ra), .rd_data(cur_rd));
  mflge_ram #(.W(MW), .D(MAX_NODES)) u_mark (
    .clk(clk), .wr_en(mark_we), .wr_addr(mark_wa), .wr_data(mark_wd),
    .rd_addr(mark_ra), .rd_data(mark_rd));
  mflge_ram #(.W(NW), .D(MAX_NODES)) u_queue (
    .clk(clk), .wr_en(queue_we), .wr_addr(queue_wa), .wr_data(queue_wd),
    .rd_addr(queue_ra), .rd_data(queue_rd));
  mflge_ram #(.W(AW), .D(MAX_NODES)) u_stack (
    .clk(clk), .wr_en(stack_we), .wr_addr(stack_wa), .wr_data(stack_wd),
    .rd_addr(stack_ra), .rd_data(stack_rd));
  mflge_ram #(.W(NW), .D(ARCS)) u_head (
    .clk(clk), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
    .rd_addr(head_ra), .rd_data(head_rd));
  mflge_ram #(.W(CW), .D(ARCS)) u_res (
    .clk(clk), .wr_en(res_we), .wr_addr(res_wa), .wr_data(res_wd),
    .rd_addr(res_ra), .rd_data(res_rd));
  mflge_ram #(.W(PW), .D(ARCS)) u_next (
    .clk(clk), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
    .rd_addr(next_ra), .rd_data(next_rd));

  `CHK_ALWAYS(a_cnt_even, !cnt_r[0], "arc count went odd")
  `CHK_ALWAYS(a_depth_bound, depth_r < DW'(MAX_NODES), "path stack overran")
  `CHK_IMPLY(a_out_from_done, $rose(out_valid_r), $past(cmd.op) == OP_DONE, "result outside done")

endmodule

[test/max_flow_level_graph_engine_top_tb.sv]
// Self-checking testbench for the max-flow engine: edge streams in, flow values checked.
module max_flow_level_graph_engine_top_tb;
  import mflge_pkg::*;

  localparam int NODES     = DEF_MAX_NODES;
  localparam int ARC_SLOTS = 2 * DEF_MAX_EDGES;
  localparam int NO_ARC    = -1;
  // Covers the post-result sweep.
  localparam int SETTLE    = 1200;
  localparam int CYCLE_CAP = 3000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SOURCE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  max_flow_level_graph_engine_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the engine: configuration, arc store and Dinic scratch.
  logic [7:0] src_reg = 8'd0;
  logic [7:0] snk_reg = 8'd1;
  int     arc_hd[ARC_SLOTS];
  longint arc_cp[ARC_SLOTS];
  longint arc_fl[ARC_SLOTS];
  int     arc_link[ARC_SLOTS];
  int     head_arc[NODES];
  int     cur_arc[NODES];
  int     lvl[NODES];
  bit     seen[NODES];
  int     bfs_q[NODES];
  int     path[NODES];
  int     n_arcs;
  bit     store_full;

  out_item_t flow_q[$];   // flow values still owed by the engine
  int  errors = 0;
  int  cycles = 0;
  bit  calm = 1'b0;       // no random idling on either side while set
  int  hold_req = 0;      // long output hold requested by a test
  int  rand_items = 0;

  function automatic void clear_graph();
    for (int v = 0; v < NODES; v++) head_arc[v] = NO_ARC;
    n_arcs = 0;
    store_full = 1'b0;
  endfunction

  function automatic longint resid(int a);
    return arc_cp[a] - arc_fl[a];
  endfunction

  function automatic void add_arc(int tail, int hd, longint cap);
    arc_hd[n_arcs] = hd;
    arc_cp[n_arcs] = cap;
    arc_fl[n_arcs] = 0;
    arc_link[n_arcs] = head_arc[tail];
    head_arc[tail] = n_arcs;
    n_arcs++;
  endfunction

  function automatic bit build_levels(int s, int t);
    int qh, qt, x, a, h;
    qh = 0;
    qt = 0;
    for (int v = 0; v < NODES; v++) seen[v] = 1'b0;
    bfs_q[qt++] = s;
    seen[s] = 1'b1;
    lvl[s] = 0;
    while (qh < qt) begin
      x = bfs_q[qh++];
      for (a = head_arc[x]; a != NO_ARC; a = arc_link[a]) begin
        h = arc_hd[a];
        if (!seen[h] && resid(a) > 0 && qt < NODES) begin
          seen[h] = 1'b1;
          lvl[h] = lvl[x] + 1;
          bfs_q[qt++] = h;
        end
      end
    end
    return seen[t];
  endfunction

  function automatic longint push_blocking(int s, int t);
    longint pushed, b;
    int depth, u, a, cut, p, parent;
    pushed = 0;
    depth = 0;
    for (int v = 0; v < NODES; v++) cur_arc[v] = head_arc[v];
    forever begin
      u = (depth == 0) ? s : arc_hd[path[depth-1]];
      if (u == t) begin
        // Saturate the bottleneck and back up to just before it.
        b = resid(path[0]);
        cut = 0;
        for (int i = 1; i < depth; i++)
          if (resid(path[i]) < b) begin
            b = resid(path[i]);
            cut = i;
          end
        for (int i = 0; i < depth; i++) begin
          arc_fl[path[i]] += b;
          arc_fl[path[i] ^ 1] -= b;
        end
        pushed += b;
        depth = cut;
        continue;
      end
      a = cur_arc[u];
      while (a != NO_ARC) begin
        if (resid(a) > 0 && seen[arc_hd[a]] && lvl[arc_hd[a]] == lvl[u] + 1) break;
        a = arc_link[a];
      end
      cur_arc[u] = a;
      if (a != NO_ARC && depth < NODES) begin
        path[depth++] = a;
        continue;
      end
      if (depth == 0) break;
      depth--;
      p = path[depth];
      parent = (depth == 0) ? s : arc_hd[path[depth-1]];
      cur_arc[parent] = arc_link[p];
    end
    return pushed;
  endfunction

  // Fold one accepted edge into the shadow; queue a flow value on the last one.
  function automatic void predict_edge(in_item_t e);
    longint total;
    out_item_t r;
    if (n_arcs + 2 <= ARC_SLOTS) begin
      add_arc(e.edge_from, e.edge_to, e.edge_capacity);
      add_arc(e.edge_to, e.edge_from, 0);
    end else begin
      store_full = 1'b1;
    end
    if (!e.last_edge) return;
    total = 0;
    if (src_reg != snk_reg)
      while (build_levels(src_reg, snk_reg)) total += push_blocking(src_reg, snk_reg);
    r.total_flow = total[FLOW_W-1:0];
    r.edges_dropped = store_full;
    flow_q.insert(flow_q.size(), r);
    clear_graph();
  endfunction

  // Check each accepted flow value against the oldest one owed.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (flow_q.size() == 0) begin
        $error("unexpected result total_flow=%0d", out_data.total_flow);
        errors++;
      end else begin
        want = flow_q.pop_front();
        if (out_data.total_flow !== want.total_flow) begin
          $error("total_flow: expected %0d, actual %0d", want.total_flow, out_data.total_flow);
          errors++;
        end
        if (out_data.edges_dropped !== want.edges_dropped) begin
          $error("edges_dropped: expected %0d, actual %0d",
                 want.edges_dropped, out_data.edges_dropped);
          errors++;
        end
      end
    end
  end

  // Receiver: random stall per result, plus a long hold when a test asks for it.
  always @(posedge clk) begin
    int hold_left, stall_left;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (out_valid && !out_stall) stall_left = calm ? 0 : $urandom_range(0, 10);
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one edge after a random gap and hold it until accepted.
  task automatic send_edge(logic [7:0] f, logic [7:0] t, logic [15:0] cap, bit last);
    in_item_t e;
    int gap;
    e.edge_from = f;
    e.edge_to = t;
    e.edge_capacity = cap;
    e.last_edge = last;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= e;
    do @(posedge clk); while (in_stall);
    predict_edge(e);
  endtask

  // Hold off until every flow value is in, then let the engine settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (flow_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_ends(logic [7:0] s, logic [7:0] t);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SOURCE;
    cfg_wdata <= s;
    @(posedge clk);
    src_reg = s;
    cfg_index <= REG_SINK;
    cfg_wdata <= t;
    @(posedge clk);
    snk_reg = t;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] pick_node();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return src_reg;
    if (r < 4) return snk_reg;
    if (r < 9) return 8'($urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_cap();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'($urandom_range(0, 65535));
    if (r == 2) return 16'hFFFF;
    return 16'($urandom_range(1, 100));
  endfunction

  // One graph of n random edges.
  task automatic send_graph(int n);
    for (int i = 0; i < n; i++) begin
      send_edge(pick_node(), pick_node(), pick_cap(), i == n - 1);
      rand_items++;
    end
  endtask

  task automatic test_directed();
    send_edge(8'd0, 8'd1, 16'hFFFF, 1'b1);          // single full-scale edge
    send_edge(8'd0, 8'd1, 16'd0, 1'b1);             // zero capacity
    send_edge(8'd0, 8'd0, 16'd500, 1'b0);           // self loop
    send_edge(8'd0, 8'd255, 16'd7, 1'b0);
    send_edge(8'd255, 8'd1, 16'd9, 1'b1);           // through the top node
    // Two paths from node 0 to node 1, with cross arcs from node 2 to node 3.
    send_edge(8'd0, 8'd2, 16'd10, 1'b0);
    send_edge(8'd0, 8'd3, 16'd10, 1'b0);
    send_edge(8'd2, 8'd3, 16'd1, 1'b0);
    send_edge(8'd2, 8'd1, 16'd10, 1'b0);
    send_edge(8'd3, 8'd1, 16'd10, 1'b0);
    send_edge(8'd2, 8'd3, 16'd5, 1'b1);
    // Parallel full-scale arcs: large total.
    for (int i = 0; i < 4; i++) send_edge(8'd0, 8'd1, 16'hFFFF, i == 3);
    send_edge(8'd1, 8'd0, 16'd30, 1'b1);            // wrong direction only
    send_edge(8'd170, 8'd85, 16'hAAAA, 1'b0);
    send_edge(8'd85, 8'd170, 16'h5555, 1'b1);       // sink unreachable
  endtask

  task automatic test_register_extremes();
    set_ends(8'd255, 8'd0);
    send_edge(8'd255, 8'd0, 16'd123, 1'b1);
    for (int g = 0; g < 4; g++) send_graph($urandom_range(1, 16));
    set_ends(8'd9, 8'd9);                           // source equals sink
    send_edge(8'd9, 8'd9, 16'd44, 1'b0);
    send_edge(8'd9, 8'd3, 16'd44, 1'b1);
    set_ends(8'd0, 8'd255);
    for (int g = 0; g < 4; g++) send_graph($urandom_range(1, 16));
    set_ends(8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)));
    for (int g = 0; g < 4; g++) send_graph($urandom_range(1, 16));
    set_ends(8'd0, 8'd1);
  endtask

  task automatic test_store_overflow();
    // Fill the store exactly, then drop two more, the last one among them.
    send_edge(8'd0, 8'd1, 16'd77, 1'b0);
    calm = 1'b1;
    for (int i = 1; i < DEF_MAX_EDGES; i++)
      send_edge(8'($urandom_range(5, 6)), 8'($urandom_range(5, 6)),
                16'($urandom_range(0, 65535)), 1'b0);
    send_edge(8'd0, 8'd1, 16'd1000, 1'b0);
    send_edge(8'd0, 8'd1, 16'd1000, 1'b1);
    calm = 1'b0;
    drain();
    send_edge(8'd0, 8'd1, 16'd3, 1'b1);             // flag must be cleared again
  endtask

  task automatic test_backpressure();
    drain();
    hold_req = 400;
    for (int g = 0; g < 5; g++) send_graph($urandom_range(1, 6));
    drain();
  endtask

  task automatic test_random();
    int g;
    g = 0;
    while (rand_items < 550) begin
      calm = (g % 12) >= 9;
      send_graph(($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20));
      if (g % 15 == 14) drain();
      g++;
    end
    calm = 1'b0;
  endtask

  initial begin
    clear_graph();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_store_overflow();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[max_flow_level_graph_engine_top.f]
+incdir+rtl
rtl/mflge_pkg.sv
rtl/mflge_ram.sv
rtl/mflge_ctrl.sv
rtl/mflge_dp.sv
rtl/max_flow_level_graph_engine_top.sv
test/max_flow_level_graph_engine_top_tb.sv
